FILE: rtl/tcbr_pkg.sv
// Shared types, codes and glyph tables for the text cell renderer.
package tcbr_pkg;

	localparam int CELL_LINES = 8;
	localparam int PLANES     = 4;
	localparam int BEATS      = CELL_LINES * PLANES;
	localparam int BEAT_W     = $clog2(BEATS);
	localparam int ROW_W      = $clog2(CELL_LINES);
	localparam int PLANE_W    = $clog2(PLANES);
	localparam int FONT_AW    = 9;
	localparam int FONT_DEPTH = 1 << FONT_AW;
	localparam int FIDX_W     = FONT_AW - ROW_W;
	localparam int OFF_W      = 15;

	localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(BEATS - 1);

	// item kinds carried on tuser
	localparam logic FUNC_DRAW = 1'b0;
	localparam logic FUNC_FONT = 1'b1;

	// configuration register indexes
	localparam logic CFG_SCREEN = 1'b0;
	localparam logic CFG_FONT   = 1'b1;

	// hollow box shown when no glyph exists; row j sits in bits [8j+7:8j]
	localparam logic [63:0] MARKER_ROWS = 64'hFF81_8181_8181_81FF;

	typedef struct packed {
		logic              rev;
		logic              use_font;
		logic [FIDX_W-1:0] fidx;
		logic [63:0]       rows;
	} glyph_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] rows;
	} box_t;

	typedef struct packed {
		logic              ok;
		logic [FIDX_W-1:0] fidx;
	} ascii_t;

	function automatic box_t box_lookup(input logic [6:0] base);
		box_t b;
		b.hit = 1'b1;
		case (base)
			7'd32:   b.rows = 64'h0000_0000_0000_0000;
			7'd64:   b.rows = 64'h0000_00FF_FF00_0000;
			7'd93:   b.rows = 64'h1818_1818_1818_1818;
			7'd112:  b.rows = 64'h1818_181F_1F00_0000;
			7'd110:  b.rows = 64'h1818_18F8_F800_0000;
			7'd109:  b.rows = 64'h0000_001F_1F18_1818;
			7'd125:  b.rows = 64'h0000_00F8_F818_1818;
			7'd107:  b.rows = 64'h1818_181F_1F18_1818;
			7'd115:  b.rows = 64'h1818_18F8_F818_1818;
			7'd114:  b.rows = 64'h1818_18FF_FF00_0000;
			7'd113:  b.rows = 64'h0000_00FF_FF18_1818;
			7'd91:   b.rows = 64'h1818_18FF_FF18_1818;
			7'd98:   b.rows = 64'hFFFF_FFFF_0000_0000;
			7'd100:  b.rows = 64'hFF00_0000_0000_0000;
			7'd30:   b.rows = 64'h0018_1818_187E_3C18;
			7'd31:   b.rows = 64'h0000_1030_7E30_1000;
			7'd81:   b.rows = 64'h003C_7EFF_FF7E_3C00;
			default: begin
				b.hit  = 1'b0;
				b.rows = 64'h0;
			end
		endcase
		return b;
	endfunction

	// font entry index is the ASCII value minus 32
	function automatic ascii_t ascii_lookup(input logic [6:0] base);
		ascii_t a;
		a.ok = 1'b1;
		case (base) inside
			7'd0:            a.fidx = FIDX_W'(32);
			[7'd1:7'd26]:    a.fidx = FIDX_W'(base) + FIDX_W'(32);
			7'd27:           a.fidx = FIDX_W'(59);
			7'd29:           a.fidx = FIDX_W'(61);
			[7'd32:7'd63]:   a.fidx = FIDX_W'(base - 7'd32);
			default: begin
				a.ok   = 1'b0;
				a.fidx = '0;
			end
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/text_cell_to_bitplane_renderer.sv
// Text cell renderer: emits 32 planar framebuffer byte writes per drawn cell.
//
//  channel   | dir | transfer
//  ----------+-----+-----------------------------------------------------
//  s_axis    | in  | draw item or font store byte (tuser selects)
//  m_axis    | out | one framebuffer byte write, tlast on the 32nd of a cell
//  cfg       | in  | register write: index 0 screen_enabled, 1 font_present
//
// A drawn cell is walked by the row/plane beat counter, one byte write per cycle
// while m_axis does not stall; the next cell is taken on the last beat so cells
// run back to back. Font rows come from a 512x8 store with a registered read.
// Font loads and clipped draws are taken when the sequencer is idle or on its
// last beat. Reset clears control state only; the font store holds garbage until
// loaded. A stall on m_axis freezes the whole pipeline while the sequencer is busy.
module text_cell_to_bitplane_renderer
	import tcbr_pkg::*;
#(
	parameter int COLS       = 40,
	parameter int ROWS       = 25,
	parameter int LINE_BYTES = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] cell_col, [15:8] cell_row, [23:16] char_code, [27:24] colour_index,
	// [36:28] font_addr, [44:37] font_bits, [47:45] zero
	input  logic [47:0] s_axis_tdata,
	// [0] func
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [14:0] byte_offset, [22:15] pixel_byte, [23] zero
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	localparam logic [OFF_W-1:0] LINE_STEP = OFF_W'(LINE_BYTES % (1 << OFF_W));
	localparam logic [OFF_W-1:0] CELL_STEP =
		OFF_W'((CELL_LINES * LINE_BYTES) % (1 << OFF_W));

	logic [7:0]         in_col, in_row;
	logic [7:0]         in_code;
	logic [3:0]         in_colour;
	logic [FONT_AW-1:0] in_faddr;
	logic [7:0]         in_fbits;

	assign in_col    = s_axis_tdata[7:0];
	assign in_row    = s_axis_tdata[15:8];
	assign in_code   = s_axis_tdata[23:16];
	assign in_colour = s_axis_tdata[27:24];
	assign in_faddr  = s_axis_tdata[36:28];
	assign in_fbits  = s_axis_tdata[44:37];

	// configuration
	logic screen_en_q, font_present_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_en_q    <= 1'b0;
			font_present_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SCREEN) screen_en_q <= cfg_data;
			if (cfg_index == CFG_FONT)   font_present_q <= cfg_data;
		end
	end

	// glyph selection at accept
	glyph_t glyph;

	tcbr_glyph_sel u_glyph_sel (
		.char_code    (in_code),
		.font_present (font_present_q),
		.glyph        (glyph)
	);

	// handshake and sequencer control
	logic adv, acc, start, font_wr;
	logic busy_q;
	logic [BEAT_W-1:0] beat_q;
	logic m_valid_q;

	assign adv           = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !busy_q || (beat_q == LAST_BEAT && adv);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign font_wr       = acc && s_axis_tuser == FUNC_FONT;
	assign start         = acc && s_axis_tuser == FUNC_DRAW && screen_en_q
	                       && in_col < 8'(COLS) && in_row < 8'(ROWS);

	// stage 1: per-cell state, beat counter walks rows with planes inside
	logic [3:0]        colour_q;
	logic              rev_q, use_font_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [63:0]       rows_q;
	logic [OFF_W-1:0]  line_q;
	logic [OFF_W-1:0]  cell_base;

	assign cell_base = OFF_W'({7'd0, in_row} * CELL_STEP)
	                   + {5'd0, in_col[7:1], 3'b000}
	                   + {{(OFF_W-1){1'b0}}, in_col[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			beat_q <= '0;
		end else if (busy_q && adv) begin
			beat_q <= beat_q + 1'b1;
			if (beat_q == LAST_BEAT) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			colour_q   <= in_colour;
			rev_q      <= glyph.rev;
			use_font_q <= glyph.use_font;
			fidx_q     <= glyph.fidx;
			rows_q     <= glyph.rows;
			line_q     <= cell_base;
		end else if (busy_q && adv && beat_q[PLANE_W-1:0] == PLANE_W'(PLANES - 1)) begin
			line_q <= line_q + LINE_STEP;
		end
	end

	// font store: write on load transfer, read one row per beat
	logic [7:0] font_mem [FONT_DEPTH];
	logic [7:0] font_rd_s2;

	always_ff @(posedge clk) begin
		if (font_wr) font_mem[in_faddr] <= in_fbits;
	end

	always_ff @(posedge clk) begin
		if (adv) font_rd_s2 <= font_mem[{fidx_q, beat_q[BEAT_W-1:PLANE_W]}];
	end

	// stage 2
	logic             valid_s2, last_s2, on_s2, rev_s2, font_s2;
	logic [OFF_W-1:0] off_s2;
	logic [7:0]       row_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s2  <= line_q + {{(OFF_W-PLANE_W-1){1'b0}}, beat_q[PLANE_W-1:0], 1'b0};
			row_s2  <= rows_q[beat_q[BEAT_W-1:PLANE_W]*8 +: 8];
			on_s2   <= colour_q[beat_q[PLANE_W-1:0]];
			rev_s2  <= rev_q;
			font_s2 <= use_font_q;
			last_s2 <= beat_q == LAST_BEAT;
		end
	end

	// output register
	logic [7:0] pix;
	logic [7:0] pix_src;
	logic [OFF_W-1:0] out_off_q;
	logic [7:0] out_pix_q;
	logic       out_last_q;

	assign pix_src = font_s2 ? font_rd_s2 : row_s2;
	assign pix     = on_s2 ? (pix_src ^ {8{rev_s2}}) : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_off_q  <= off_s2;
			out_pix_q  <= pix;
			out_last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, out_pix_q, out_off_q};
	assign m_axis_tlast  = out_last_q;

	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && busy_q) |-> (beat_q == LAST_BEAT && adv))
		else $error("item taken mid-cell");

	a_beat_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && adv && beat_q != LAST_BEAT && !start) |=> (beat_q == $past(beat_q) + 1'b1))
		else $error("beat counter skipped");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && beat_q == '0))
		else $error("cell did not start at beat zero");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !adv && !start) |=> (busy_q && $stable(beat_q)))
		else $error("sequencer moved during output stall");

endmodule

FILE: rtl/tcbr_glyph_sel.sv
// Picks the glyph source for a screen code: box table, font store or marker.
module tcbr_glyph_sel
	import tcbr_pkg::*;
(
	input  logic [7:0] char_code,
	input  logic       font_present,
	output glyph_t     glyph
);

	box_t   box;
	ascii_t asc;

	always_comb begin
		box            = box_lookup(char_code[6:0]);
		asc            = ascii_lookup(char_code[6:0]);
		glyph.rev      = char_code[7];
		glyph.use_font = 1'b0;
		glyph.fidx     = asc.fidx;
		if (box.hit) begin
			glyph.rows = box.rows;
		end else if (asc.ok && font_present) begin
			glyph.use_font = 1'b1;
			glyph.rows     = MARKER_ROWS;
		end else begin
			glyph.rows = MARKER_ROWS;
		end
	end

endmodule

FILE: test/tb.sv
// Self-checking testbench for the text cell renderer: directed cells, then random stream traffic.
module tb;
	import tcbr_pkg::*;

	localparam int COLS           = 40;
	localparam int ROWS           = 25;
	localparam int LINE_BYTES     = 160;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 430;
	// row 0 in the top byte, row 7 in the bottom byte
	localparam logic [63:0] HOLLOW_BOX = 64'hFF81_8181_8181_81FF;

	typedef struct packed {
		logic [14:0] offset;
		logic [7:0]  pixels;
		logic        last;
	} fb_write_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = FUNC_DRAW;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_index     = CFG_SCREEN;
	logic        cfg_data      = 1'b0;

	// shadow of the block's registers and font store
	logic        scr_en = 1'b0;
	logic        font_en = 1'b0;
	logic [7:0]  font_copy [FONT_DEPTH];
	bit          font_written [FONT_DEPTH];

	fb_write_t   pending_writes[$];
	bit          idle_en = 1'b1;
	int          items_sent = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;

	text_cell_to_bitplane_renderer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= !idle_en || ($urandom_range(99) >= 12);
	end

	// {hit, rows} for the fixed line-drawing set
	function automatic logic [64:0] line_art_rows(input logic [6:0] base);
		case (base)
			7'd32:   return {1'b1, 64'h0000_0000_0000_0000};
			7'd64:   return {1'b1, 64'h0000_00FF_FF00_0000};
			7'd93:   return {1'b1, 64'h1818_1818_1818_1818};
			7'd112:  return {1'b1, 64'h0000_001F_1F18_1818};
			7'd110:  return {1'b1, 64'h0000_00F8_F818_1818};
			7'd109:  return {1'b1, 64'h1818_181F_1F00_0000};
			7'd125:  return {1'b1, 64'h1818_18F8_F800_0000};
			7'd107:  return {1'b1, 64'h1818_181F_1F18_1818};
			7'd115:  return {1'b1, 64'h1818_18F8_F818_1818};
			7'd114:  return {1'b1, 64'h0000_00FF_FF18_1818};
			7'd113:  return {1'b1, 64'h1818_18FF_FF00_0000};
			7'd91:   return {1'b1, 64'h1818_18FF_FF18_1818};
			7'd98:   return {1'b1, 64'h0000_0000_FFFF_FFFF};
			7'd100:  return {1'b1, 64'h0000_0000_0000_00FF};
			7'd30:   return {1'b1, 64'h183C_7E18_1818_1800};
			7'd31:   return {1'b1, 64'h0010_307E_3010_0000};
			7'd81:   return {1'b1, 64'h003C_7EFF_FF7E_3C00};
			default: return {1'b0, 64'h0};
		endcase
	endfunction

	// ASCII value of a screen code, zero when it has none
	function automatic logic [7:0] ascii_of(input logic [6:0] base);
		if (base == 7'd0)
			return 8'd64;
		if (base <= 7'd26)
			return 8'd64 + 8'(base);
		if (base == 7'd27)
			return 8'd91;
		if (base == 7'd29)
			return 8'd93;
		if (base >= 7'd32 && base <= 7'd63)
			return 8'(base);
		return 8'd0;
	endfunction

	function automatic logic [8:0] font_entry(input logic [7:0] asc, input int glyph_row);
		return 9'((int'(asc) - 32) * 8 + glyph_row);
	endfunction

	function automatic bit glyph_loaded(input logic [7:0] asc);
		for (int j = 0; j < CELL_LINES; j++)
			if (!font_written[font_entry(asc, j)])
				return 1'b0;
		return 1'b1;
	endfunction

	// queue the 32 framebuffer writes a drawn cell should produce
	task automatic render_cell(input logic [7:0] col, row, code, input logic [3:0] colour);
		logic [64:0] bx;
		logic [63:0] glyph;
		logic [7:0]  asc;
		fb_write_t   w;
		int unsigned off;
		int          n;
		if (!scr_en || col >= COLS || row >= ROWS)
			return;
		bx = line_art_rows(code[6:0]);
		glyph = bx[63:0];
		if (!bx[64]) begin
			asc = ascii_of(code[6:0]);
			if (asc != 8'd0 && font_en) begin
				for (int j = 0; j < CELL_LINES; j++)
					glyph[63 - 8 * j -: 8] = font_copy[font_entry(asc, j)];
			end else begin
				glyph = HOLLOW_BOX;
			end
		end
		if (code[7])
			glyph = ~glyph;
		n = 0;
		for (int r = 0; r < CELL_LINES; r++) begin
			for (int p = 0; p < PLANES; p++) begin
				off = (int'(row) * CELL_LINES + r) * LINE_BYTES + (int'(col) >> 1) * 8
				      + p * 2 + (int'(col) & 1);
				w.offset = off[14:0];
				w.pixels = colour[p] ? glyph[63 - 8 * r -: 8] : 8'h00;
				w.last   = (n == CELL_LINES * PLANES - 1);
				pending_writes.push_back(w);
				n++;
			end
		end
	endtask

	// one item on s_axis; the shadow copy is updated at the accepting edge
	task automatic send_item(input logic func, input logic [47:0] data);
		if (idle_en)
			while ($urandom_range(99) < 12) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (func == FUNC_FONT) begin
			font_copy[data[36:28]]    = data[44:37];
			font_written[data[36:28]] = 1'b1;
		end else begin
			render_cell(data[7:0], data[15:8], data[23:16], data[27:24]);
		end
	endtask

	task automatic load_font_byte(input logic [8:0] addr, input logic [7:0] bits);
		send_item(FUNC_FONT, {3'b0, bits, addr, 4'($urandom), 8'($urandom), 8'($urandom),
		                      8'($urandom)});
	endtask

	task automatic load_glyph(input logic [7:0] asc);
		for (int j = 0; j < CELL_LINES; j++)
			load_font_byte(font_entry(asc, j), 8'($urandom));
	endtask

	// load the glyph first whenever the draw would read unwritten font rows
	task automatic draw_cell(input logic [7:0] col, row, code, input logic [3:0] colour);
		logic [64:0] bx;
		logic [7:0]  asc;
		bx  = line_art_rows(code[6:0]);
		asc = ascii_of(code[6:0]);
		if (font_en && !bx[64] && asc != 8'd0 && !glyph_loaded(asc))
			load_glyph(asc);
		send_item(FUNC_DRAW, {3'b0, 8'($urandom), 9'($urandom), colour, code, row, col});
	endtask

	task automatic random_item();
		logic [7:0] col;
		logic [7:0] row;
		if ($urandom_range(99) < 25) begin
			load_font_byte(9'($urandom_range(511)), 8'($urandom));
		end else begin
			col = ($urandom_range(99) < 90) ? 8'($urandom_range(39)) : 8'($urandom_range(255, 40));
			row = ($urandom_range(99) < 90) ? 8'($urandom_range(24)) : 8'($urandom_range(255, 25));
			draw_cell(col, row, 8'($urandom), 4'($urandom));
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SCREEN)
			scr_en = val;
		else
			font_en = val;
	endtask

	task automatic set_regs(input logic screen, input logic font);
		wait_idle();
		write_reg(CFG_SCREEN, screen);
		write_reg(CFG_FONT, font);
		cfg_valid <= 1'b0;
	endtask

	// registers at reset: nothing drawn, font loads still land
	task automatic test_screen_off();
		draw_cell(8'd0, 8'd0, 8'd1, 4'hF);
		load_font_byte(9'd0, 8'hFF);
		load_font_byte(9'd511, 8'h00);
	endtask

	task automatic test_box_and_marker();
		set_regs(1'b1, 1'b0);
		draw_cell(8'd0, 8'd0, 8'd32, 4'hF);
		draw_cell(8'd39, 8'd24, 8'h80 | 8'd81, 4'b1010);
		// letter with no font loaded falls to the hollow box
		draw_cell(8'd1, 8'd0, 8'd1, 4'h0);
		draw_cell(8'd38, 8'd1, 8'hFF, 4'hF);
	endtask

	task automatic test_clipping();
		draw_cell(8'd40, 8'd0, 8'd30, 4'hF);
		draw_cell(8'd0, 8'd25, 8'd31, 4'hF);
		draw_cell(8'd255, 8'd255, 8'd0, 4'hF);
	endtask

	task automatic test_font_glyphs();
		set_regs(1'b1, 1'b1);
		draw_cell(8'd2, 8'd3, 8'd1, 4'b0101);
		draw_cell(8'd20, 8'd12, 8'h81, 4'hF);
		draw_cell(8'd21, 8'd12, 8'd28, 4'b0011);
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		repeat (40) random_item();
		drain();
		idle_en = 1'b1;
	endtask

	task automatic test_random_phases();
		int ph;
		ph = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (ph)
				0:       set_regs(1'b1, 1'b1);
				1:       set_regs(1'b1, 1'b0);
				2:       set_regs(1'b0, 1'b1);
				default: set_regs(($urandom_range(99) < 75), 1'($urandom));
			endcase
			for (int i = 0; i < 50 && items_sent < RANDOM_ITEMS; i++) begin
				// hold the sender until every queued write has come out
				if (ph == 1 && i == 25)
					drain();
				random_item();
			end
			ph++;
		end
	endtask

	always @(posedge clk) begin : check_writes
		fb_write_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected write: offset %0d byte %h last %b",
					         m_axis_tdata[14:0], m_axis_tdata[22:15], m_axis_tlast);
			end else begin
				want = pending_writes.pop_front();
				if (m_axis_tdata[14:0] !== want.offset || m_axis_tdata[22:15] !== want.pixels
				    || m_axis_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("write mismatch: expected offset %0d byte %h last %b, got %0d %h %b",
						         want.offset, want.pixels, want.last,
						         m_axis_tdata[14:0], m_axis_tdata[22:15], m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
		    || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_screen_off();
		test_box_and_marker();
		test_clipping();
		test_font_glyphs();
		test_back_to_back();
		test_random_phases();
		wait_idle();
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
